/* rtl/bdac_pkg.sv */
// Package for the binary to decimal ASCII converter.
// Holds widths, character codes, payload structs, FSM codes and the BCD adjust function.
// No dependencies.
package bdac_pkg;

  localparam int MAX_DIGITS  = 20;
  localparam int NumCells    = 20;
  localparam int ValueW      = 64;
  localparam int HalfW       = ValueW / 2;
  localparam int CharW       = 8;
  localparam int DigitW      = 4;
  localparam int BitsPerStep = 2;
  localparam int SignedSteps = ValueW / BitsPerStep;
  localparam int UnsignedSteps = HalfW / BitsPerStep;
  localparam int StepW       = $clog2(SignedSteps);
  localparam int CountW      = $clog2(NumCells + 1);
  localparam int IdxW        = $clog2(NumCells);

  localparam logic [CharW-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  localparam logic KindSigned   = 1'b0;
  localparam logic KindUnsigned = 1'b1;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } out_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StConv  = 4'b0010,
    StCount = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  // Add-3 correction applied to a BCD digit before it is doubled.
  function automatic digit_t dabble_adj(digit_t d);
    digit_t r;
    r = (d >= DabbleLimit) ? digit_t'(d + DabbleAdd) : d;
    return r;
  endfunction

endpackage

/* rtl/bdac_cell.sv */
// One decimal digit cell of the shift-and-add-3 chain; two binary bits enter per cycle while shift is set.
// Depends on bdac_pkg.
module bdac_cell (
  input  logic                       clk_i,
  input  bdac_pkg::cell_ctrl_t       ctrl_i,
  input  logic [1:0]                 bits_i,
  output logic [1:0]                 bits_o,
  output bdac_pkg::digit_t           digit_o
);
  import bdac_pkg::*;

  digit_t digit_q, digit_d;
  digit_t adj1, mid, adj2;

  // The bits handed upward depend only on this cell's digit and the lower
  // cell's first output bit, so the chain never ripples across many cells.
  always_comb begin
    adj1    = dabble_adj(digit_q);
    mid     = {adj1[DigitW-2:0], bits_i[1]};
    adj2    = dabble_adj(mid);
    bits_o  = {adj1[DigitW-1], adj2[DigitW-1]};
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj2[DigitW-2:0], bits_i[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: a row of BCD digit cells takes two magnitude bits a cycle while converting.
// Sequence: 32 (signed) or 16 (unsigned) conversion steps, then a count state, then the characters, sign first.
// A new request is taken only when idle, once the last character is loaded into the output register.
// Reset: rst_ni is asynchronous, active low; it returns the FSM to idle and empties the output.
// Depends on bdac_pkg and bdac_cell.
module binary_to_decimal_ascii (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bdac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bdac_pkg::out_t out_data_o
);
  import bdac_pkg::*;

  state_e state_q, state_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  cell_ctrl_t        cell_ctrl;
  logic [1:0]        chain [NumCells];
  digit_t            digits [NumCells];

  logic              in_fire;
  logic              out_load;
  logic [CountW-1:0] sig_count;
  logic [ValueW-1:0] raw;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  assign cell_ctrl.clear = in_fire;
  assign cell_ctrl.shift = (state_q == StConv);

  assign chain[0] = mag_q[ValueW-1 -: BitsPerStep];

  for (genvar i = 0; i < NumCells; i++) begin : g_cells
    if (i == NumCells - 1) begin : g_top
      bdac_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .bits_i (chain[i]),
        .bits_o (),
        .digit_o(digits[i])
      );
    end else begin : g_mid
      bdac_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .bits_i (chain[i]),
        .bits_o (chain[i+1]),
        .digit_o(digits[i])
      );
    end
  end

  // Number of significant digits, at least one, clipped to the emit limit.
  always_comb begin
    sig_count = '0;
    for (int i = 0; i < NumCells; i++) begin
      if (digits[i] != '0) begin
        sig_count = CountW'(i + 1);
      end
    end
    if (sig_count == '0) begin
      sig_count = CountW'(1);
    end
    if (sig_count > CountW'(MAX_DIGITS)) begin
      sig_count = CountW'(MAX_DIGITS);
    end
  end

  assign out_load = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign raw      = in_data_i.value;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    step_d      = step_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StConv;
          if (in_data_i.kind == KindUnsigned) begin
            neg_d  = 1'b0;
            mag_d  = {raw[HalfW-1:0], {HalfW{1'b0}}};
            step_d = StepW'(UnsignedSteps - 1);
          end else begin
            neg_d  = raw[ValueW-1];
            mag_d  = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
            step_d = StepW'(SignedSteps - 1);
          end
        end
      end
      StConv: begin
        mag_d = mag_q << BitsPerStep;
        if (step_q == '0) begin
          state_d = StCount;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      StCount: begin
        idx_d   = IdxW'(sig_count - CountW'(1));
        state_d = StEmit;
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_d.character = CHAR_MINUS;
            out_d.last      = 1'b0;
            neg_d           = 1'b0;
          end else begin
            out_d.character = CHAR_ZERO + {{(CharW-DigitW){1'b0}}, digits[idx_q]};
            out_d.last      = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      neg_q       <= neg_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* test/binary_to_decimal_ascii_tb.sv */
// Self-checking testbench for binary_to_decimal_ascii: directed corner values, then random
// requests under three idle/stall patterns, each character checked against a local predictor.
// Depends on bdac_pkg and the binary_to_decimal_ascii RTL.
module binary_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdac_pkg::*;

  localparam int Radix      = 10;
  localparam int MaxReports = 10;
  localparam int StallLimit = 3000;
  localparam int DrainCycles = 60;
  localparam int RandomPerPhase = 80;

  // Keeps the characters still owed by the block and compares each one that comes out.
  class decimal_scoreboard;
    out_t pending[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out the decimal text of one accepted request.
    function void note_request(in_t req);
      logic [ValueW-1:0] mag;
      digit_t            digs[MAX_DIGITS];
      int                cnt;
      bit                neg;
      neg = 1'b0;
      if (req.kind == KindUnsigned) begin
        mag = {{HalfW{1'b0}}, req.value[HalfW-1:0]};
      end else if (req.value[ValueW-1]) begin
        neg = 1'b1;
        mag = ~req.value + 1'b1;
      end else begin
        mag = req.value;
      end
      cnt = 0;
      do begin
        digs[cnt] = digit_t'(mag % Radix);
        mag = mag / Radix;
        cnt++;
      end while (mag != 0 && cnt < MAX_DIGITS);
      if (neg) begin
        pending.push_back(out_t'{CHAR_MINUS, 1'b0});
      end
      for (int k = cnt - 1; k >= 0; k--) begin
        pending.push_back(out_t'{CHAR_ZERO + CharW'(digs[k]), k == 0});
      end
    endfunction

    function void check_char(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: unexpected character %h last %b", $realtime, got.character, got.last);
        end
      end else begin
        exp = pending.pop_front();
        if (got.character !== exp.character || got.last !== exp.last) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: mismatch character exp %h got %h, last exp %b got %b", $realtime,
                     exp.character, got.character, exp.last, got.last);
          end
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  decimal_scoreboard sb = new();
  int send_idle;
  int recv_idle;

  binary_to_decimal_ascii dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Called just after a rising edge; returns at the edge where the request is taken.
  // Valid is left high so the next request can follow without a gap.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic in_t random_request();
    in_t               r;
    logic [ValueW-1:0] p;
    int                n;
    r.kind  = 1'($urandom_range(1));
    r.value = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;
      1: begin
        r.value = ValueW'($urandom_range(30));
        if ($urandom_range(1)) r.value = -r.value;
      end
      2: begin
        if (r.kind == KindUnsigned) begin
          r.value[HalfW-1:0] = r.value[HalfW-1:0] >> $urandom_range(HalfW - 1);
        end else begin
          r.value = r.value >>> $urandom_range(ValueW - 1);
        end
      end
      default: begin
        // Neighbors of a power of ten exercise the digit-count boundaries.
        p = ValueW'(1);
        n = $urandom_range(r.kind == KindUnsigned ? 9 : 18);
        repeat (n) p = p * Radix;
        p = p + $urandom_range(2) - 1;
        if (r.kind == KindUnsigned) begin
          r.value[HalfW-1:0] = p[HalfW-1:0];
        end else begin
          r.value = $urandom_range(1) ? -p : p;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_char(out_data_o);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    send_idle   = 30;
    recv_idle   = 87;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(in_t'{KindSigned, 64'sd0});
    send_request(in_t'{KindSigned, 64'sd1});
    send_request(in_t'{KindSigned, -64'sd1});
    send_request(in_t'{KindSigned, 64'sd9});
    send_request(in_t'{KindSigned, 64'sd10});
    send_request(in_t'{KindSigned, -64'sd10});
    send_request(in_t'{KindSigned, 64'h7FFF_FFFF_FFFF_FFFF});
    send_request(in_t'{KindSigned, 64'h8000_0000_0000_0000});
    send_request(in_t'{KindSigned, 64'h8000_0000_0000_0001});
    send_request(in_t'{KindSigned, 64'sd999999999999999999});
    send_request(in_t'{KindSigned, 64'sd1000000000000000000});
    send_request(in_t'{KindSigned, -64'sd1000000000000000000});
    send_request(in_t'{KindSigned, 64'h0000_0001_0000_0000});
    send_request(in_t'{KindUnsigned, 64'h0});
    send_request(in_t'{KindUnsigned, {32'hFFFF_FFFF, 32'h0}});
    send_request(in_t'{KindUnsigned, {32'hDEAD_BEEF, 32'hFFFF_FFFF}});
    send_request(in_t'{KindUnsigned, {32'h0, 32'h8000_0000}});
    send_request(in_t'{KindUnsigned, {32'h8000_0000, 32'd7}});
    send_request(in_t'{KindUnsigned, 64'd999999999});
    send_request(in_t'{KindUnsigned, 64'd1000000000});
    wait_drained();

    repeat (RandomPerPhase) send_request(random_request());
    wait_drained();

    send_idle = 87;
    recv_idle = 30;
    repeat (RandomPerPhase) send_request(random_request());
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    repeat (RandomPerPhase) send_request(random_request());
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
